[design/ptri_pkg.sv]
package ptri_pkg;

  // Field widths of the ports.
  localparam int CW    = 32;   // anchor coordinate and position
  localparam int RNGW  = 31;   // measured range
  localparam int AW    = 5;    // configuration address
  localparam int DW    = 32;   // configuration data

  // Internal datapath widths.
  localparam int DLW   = CW + 1;        // anchor difference
  localparam int SQRW  = 2 * RNGW;      // squared range
  localparam int SQW   = 2 * DLW;       // product of two differences
  localparam int UW    = SQW + 2;       // right-hand sides u and v
  localparam int DTW   = SQW + 1;       // determinant
  localparam int SPL   = 34;            // split point of u and v for the products
  localparam int PLW   = SPL + 1 + DLW; // low partial product
  localparam int PHW   = UW - SPL + DLW; // high partial product
  localparam int NW    = 104;           // numerators
  localparam int QB    = 40;            // quotient bits before saturation
  localparam int DVW   = 108;           // dividend and divisor

  // Register map, one word per register.
  typedef enum logic [2:0] {
    REG_AX = 3'd0,
    REG_AY = 3'd1,
    REG_BX = 3'd2,
    REG_BY = 3'd3,
    REG_CX = 3'd4,
    REG_CY = 3'd5
  } reg_idx_t;

  localparam logic [CW-1:0] RST_AX = 32'h0000_0000;
  localparam logic [CW-1:0] RST_AY = 32'h0000_0000;
  localparam logic [CW-1:0] RST_BX = 32'h0001_0000;
  localparam logic [CW-1:0] RST_BY = 32'h0000_0000;
  localparam logic [CW-1:0] RST_CX = 32'h0000_0000;
  localparam logic [CW-1:0] RST_CY = 32'h0001_0000;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } anchors_t;

  // One stage of the divider pipeline, both coordinates side by side.
  typedef struct packed {
    logic                 vld;
    logic                 inv;
    logic                 negx;
    logic                 negy;
    logic                 satx;
    logic                 saty;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic [DVW-1:0]       remx;
    logic [DVW-1:0]       remy;
    logic [DVW-1:0]       dd;
    logic [QB-1:0]        qx;
    logic [QB-1:0]        qy;
  } dstg_t;

endpackage

[design/ptri_in_if.sv]
interface ptri_in_if;
  logic                       valid;
  logic                       ready;
  logic [ptri_pkg::RNGW-1:0]  range_a;
  logic [ptri_pkg::RNGW-1:0]  range_b;
  logic [ptri_pkg::RNGW-1:0]  range_c;

  modport source (output valid, range_a, range_b, range_c, input ready);
  modport sink   (input valid, range_a, range_b, range_c, output ready);
endinterface

[design/ptri_out_if.sv]
interface ptri_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [ptri_pkg::CW-1:0]   pos_x;
  logic signed [ptri_pkg::CW-1:0]   pos_y;
  logic                             invalid;

  modport source (output valid, pos_x, pos_y, invalid, input ready);
  modport sink   (input valid, pos_x, pos_y, invalid, output ready);
endinterface

[design/ptri_cfg.sv]
module ptri_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ptri_pkg::AW-1:0]   paddr,
  input  logic [ptri_pkg::DW-1:0]   pwdata,
  output logic [ptri_pkg::DW-1:0]   prdata,
  output ptri_pkg::anchors_t        anc
);
  import ptri_pkg::*;

  anchors_t   anc_r;
  logic [2:0] idx;

  assign idx = paddr[AW-1:2];
  assign anc = anc_r;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anc_r.ax <= RST_AX;
      anc_r.ay <= RST_AY;
      anc_r.bx <= RST_BX;
      anc_r.by <= RST_BY;
      anc_r.cx <= RST_CX;
      anc_r.cy <= RST_CY;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_AX:  anc_r.ax <= pwdata;
        REG_AY:  anc_r.ay <= pwdata;
        REG_BX:  anc_r.bx <= pwdata;
        REG_BY:  anc_r.by <= pwdata;
        REG_CX:  anc_r.cx <= pwdata;
        REG_CY:  anc_r.cy <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux; unmapped addresses read as zero.
  always_comb begin
    unique case (idx)
      REG_AX:  prdata = anc_r.ax;
      REG_AY:  prdata = anc_r.ay;
      REG_BX:  prdata = anc_r.bx;
      REG_BY:  prdata = anc_r.by;
      REG_CX:  prdata = anc_r.cx;
      REG_CY:  prdata = anc_r.cy;
      default: prdata = '0;
    endcase
  end
endmodule

[design/ptri_front.sv]
module ptri_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        ce,
  input  logic                        in_vld,
  input  logic [ptri_pkg::RNGW-1:0]   ra,
  input  logic [ptri_pkg::RNGW-1:0]   rb,
  input  logic [ptri_pkg::RNGW-1:0]   rc,
  input  ptri_pkg::anchors_t          anc,
  output ptri_pkg::dstg_t             req
);
  import ptri_pkg::*;

  // Stage 1: ranges and anchor differences relative to A.
  logic                  s1_vld_r;
  logic [RNGW-1:0]       s1_ra_r, s1_rb_r, s1_rc_r;
  logic signed [DLW-1:0] s1_dx_r, s1_dy_r, s1_ex_r, s1_ey_r;
  logic signed [CW-1:0]  s1_ax_r, s1_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (ce) begin
      s1_vld_r <= in_vld;
      s1_ra_r  <= ra;
      s1_rb_r  <= rb;
      s1_rc_r  <= rc;
      s1_dx_r  <= DLW'(anc.bx) - DLW'(anc.ax);
      s1_dy_r  <= DLW'(anc.by) - DLW'(anc.ay);
      s1_ex_r  <= DLW'(anc.cx) - DLW'(anc.ax);
      s1_ey_r  <= DLW'(anc.cy) - DLW'(anc.ay);
      s1_ax_r  <= anc.ax;
      s1_ay_r  <= anc.ay;
    end
  end

  // Stage 2: squares and cross products.
  logic                  s2_vld_r;
  logic [SQRW-1:0]       s2_ra2_r, s2_rb2_r, s2_rc2_r;
  logic signed [SQW-1:0] s2_dxx_r, s2_dyy_r, s2_exx_r, s2_eyy_r, s2_dxey_r, s2_dyex_r;
  logic signed [DLW-1:0] s2_dx_r, s2_dy_r, s2_ex_r, s2_ey_r;
  logic signed [CW-1:0]  s2_ax_r, s2_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (ce) begin
      s2_vld_r  <= s1_vld_r;
      s2_ra2_r  <= s1_ra_r * s1_ra_r;
      s2_rb2_r  <= s1_rb_r * s1_rb_r;
      s2_rc2_r  <= s1_rc_r * s1_rc_r;
      s2_dxx_r  <= s1_dx_r * s1_dx_r;
      s2_dyy_r  <= s1_dy_r * s1_dy_r;
      s2_exx_r  <= s1_ex_r * s1_ex_r;
      s2_eyy_r  <= s1_ey_r * s1_ey_r;
      s2_dxey_r <= s1_dx_r * s1_ey_r;
      s2_dyex_r <= s1_dy_r * s1_ex_r;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_ex_r   <= s1_ex_r;
      s2_ey_r   <= s1_ey_r;
      s2_ax_r   <= s1_ax_r;
      s2_ay_r   <= s1_ay_r;
    end
  end

  // Stage 3: right-hand sides u, v and the determinant.
  logic                  s3_vld_r;
  logic signed [UW-1:0]  s3_u_r, s3_v_r;
  logic signed [DTW-1:0] s3_det_r;
  logic signed [DLW-1:0] s3_dx_r, s3_dy_r, s3_ex_r, s3_ey_r;
  logic signed [CW-1:0]  s3_ax_r, s3_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (ce) begin
      s3_vld_r <= s2_vld_r;
      s3_u_r   <= UW'(s2_ra2_r) - UW'(s2_rb2_r) + UW'(s2_dxx_r) + UW'(s2_dyy_r);
      s3_v_r   <= UW'(s2_ra2_r) - UW'(s2_rc2_r) + UW'(s2_exx_r) + UW'(s2_eyy_r);
      s3_det_r <= DTW'(s2_dxey_r) - DTW'(s2_dyex_r);
      s3_dx_r  <= s2_dx_r;
      s3_dy_r  <= s2_dy_r;
      s3_ex_r  <= s2_ex_r;
      s3_ey_r  <= s2_ey_r;
      s3_ax_r  <= s2_ax_r;
      s3_ay_r  <= s2_ay_r;
    end
  end

  // Stage 4: partial products of u and v, split into low and high halves.
  logic                  s4_vld_r;
  logic signed [PLW-1:0] s4_uey_l_r, s4_vdy_l_r, s4_vdx_l_r, s4_uex_l_r;
  logic signed [PHW-1:0] s4_uey_h_r, s4_vdy_h_r, s4_vdx_h_r, s4_uex_h_r;
  logic signed [DTW-1:0] s4_det_r;
  logic signed [CW-1:0]  s4_ax_r, s4_ay_r;
  logic signed [SPL:0]   ul, vl;
  logic signed [UW-SPL-1:0] uh, vh;

  assign ul = $signed({1'b0, s3_u_r[SPL-1:0]});
  assign vl = $signed({1'b0, s3_v_r[SPL-1:0]});
  assign uh = $signed(s3_u_r[UW-1:SPL]);
  assign vh = $signed(s3_v_r[UW-1:SPL]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (ce) begin
      s4_vld_r   <= s3_vld_r;
      s4_uey_l_r <= ul * s3_ey_r;
      s4_uey_h_r <= uh * s3_ey_r;
      s4_vdy_l_r <= vl * s3_dy_r;
      s4_vdy_h_r <= vh * s3_dy_r;
      s4_vdx_l_r <= vl * s3_dx_r;
      s4_vdx_h_r <= vh * s3_dx_r;
      s4_uex_l_r <= ul * s3_ex_r;
      s4_uex_h_r <= uh * s3_ex_r;
      s4_det_r   <= s3_det_r;
      s4_ax_r    <= s3_ax_r;
      s4_ay_r    <= s3_ay_r;
    end
  end

  // Stage 5: numerators of both coordinates.
  logic                  s5_vld_r;
  logic signed [NW-1:0]  s5_nx_r, s5_ny_r;
  logic signed [DTW-1:0] s5_det_r;
  logic signed [CW-1:0]  s5_ax_r, s5_ay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (ce) begin
      s5_vld_r <= s4_vld_r;
      s5_nx_r  <= (NW'(s4_uey_h_r) <<< SPL) + NW'(s4_uey_l_r)
                - (NW'(s4_vdy_h_r) <<< SPL) - NW'(s4_vdy_l_r);
      s5_ny_r  <= (NW'(s4_vdx_h_r) <<< SPL) + NW'(s4_vdx_l_r)
                - (NW'(s4_uex_h_r) <<< SPL) - NW'(s4_uex_l_r);
      s5_det_r <= s4_det_r;
      s5_ax_r  <= s4_ax_r;
      s5_ay_r  <= s4_ay_r;
    end
  end

  // Stage 6: magnitudes, rounding offset and the saturation test.
  logic [NW-1:0]  nmx, nmy;
  logic [DTW-1:0] dm;
  logic [DVW-1:0] nnx, nny, dd;
  dstg_t          req_r;

  assign nmx = s5_nx_r[NW-1] ? NW'(-s5_nx_r) : NW'(s5_nx_r);
  assign nmy = s5_ny_r[NW-1] ? NW'(-s5_ny_r) : NW'(s5_ny_r);
  assign dm  = s5_det_r[DTW-1] ? DTW'(-s5_det_r) : DTW'(s5_det_r);
  assign nnx = DVW'(nmx) + DVW'(dm);
  assign nny = DVW'(nmy) + DVW'(dm);
  assign dd  = DVW'({dm, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.vld <= 1'b0;
    end else if (ce) begin
      req_r.vld  <= s5_vld_r;
      req_r.inv  <= (s5_det_r == '0);
      req_r.negx <= s5_nx_r[NW-1] ^ s5_det_r[DTW-1];
      req_r.negy <= s5_ny_r[NW-1] ^ s5_det_r[DTW-1];
      req_r.satx <= (nnx >= (dd << QB));
      req_r.saty <= (nny >= (dd << QB));
      req_r.ax   <= s5_ax_r;
      req_r.ay   <= s5_ay_r;
      req_r.remx <= nnx;
      req_r.remy <= nny;
      req_r.dd   <= dd;
      req_r.qx   <= '0;
      req_r.qy   <= '0;
    end
  end

  assign req = req_r;
endmodule

[design/ptri_div.sv]
module ptri_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ce,
  input  ptri_pkg::dstg_t  req,
  output ptri_pkg::dstg_t  res
);
  import ptri_pkg::*;

  dstg_t pipe_r [QB];

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < QB; k++) begin : g_stg
    localparam int B = QB - 1 - k;
    dstg_t          src, nxt;
    logic [DVW-1:0] sh;
    logic           tx, ty;

    if (k == 0) begin : g_first
      assign src = req;
    end else begin : g_next
      assign src = pipe_r[k-1];
    end

    assign sh = src.dd << B;
    assign tx = (src.remx >= sh);
    assign ty = (src.remy >= sh);

    always_comb begin
      nxt       = src;
      nxt.remx  = tx ? src.remx - sh : src.remx;
      nxt.remy  = ty ? src.remy - sh : src.remy;
      nxt.qx[B] = tx;
      nxt.qy[B] = ty;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[k].vld <= 1'b0;
      end else if (ce) begin
        pipe_r[k] <= nxt;
      end
    end
  end

  assign res = pipe_r[QB-1];
endmodule

[design/planar_trilateration.sv]
// Pipeline from an accepted request to its result on the output port:
// six arithmetic stages, one stage per quotient bit of the 40-bit divider, one output stage.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while a finished result waits on the output.
// Reset (rst_n, synchronous, active low) clears all valid bits and loads the anchor defaults.
module planar_trilateration (
  input  logic                      clk,
  input  logic                      rst_n,
  ptri_in_if.sink                   in_ch,
  ptri_out_if.source                out_ch,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [ptri_pkg::AW-1:0]   cfg_paddr,
  input  logic [ptri_pkg::DW-1:0]   cfg_pwdata,
  output logic [ptri_pkg::DW-1:0]   cfg_prdata,
  output logic                      cfg_pready
);
  import ptri_pkg::*;

  localparam int VW = QB + 3;

  anchors_t anc;
  dstg_t    req, res;
  logic     ce;

  logic                 out_vld_r;
  logic signed [CW-1:0] pos_x_r, pos_y_r;
  logic                 inv_r;

  logic [QB:0]          magx, magy;
  logic signed [VW-1:0] sx, sy;
  logic signed [CW-1:0] cx, cy;

  assign cfg_pready = 1'b1;

  // The pipeline moves whenever the output register is free or being drained.
  assign ce          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = ce;

  ptri_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .anc     (anc)
  );

  ptri_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .in_vld (in_ch.valid),
    .ra     (in_ch.range_a),
    .rb     (in_ch.range_b),
    .rc     (in_ch.range_c),
    .anc    (anc),
    .req    (req)
  );

  ptri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ce    (ce),
    .req   (req),
    .res   (res)
  );

  // Signed offset from anchor A; a saturated quotient stands in as 2^QB.
  assign magx = res.satx ? {1'b1, {QB{1'b0}}} : {1'b0, res.qx};
  assign magy = res.saty ? {1'b1, {QB{1'b0}}} : {1'b0, res.qy};
  assign sx   = (res.negx ? -$signed(VW'(magx)) : $signed(VW'(magx))) + VW'(res.ax);
  assign sy   = (res.negy ? -$signed(VW'(magy)) : $signed(VW'(magy))) + VW'(res.ay);

  // Clamp to the 32-bit signed range.
  always_comb begin
    if (!sx[VW-1] && (|sx[VW-2:CW-1])) begin
      cx = {1'b0, {(CW-1){1'b1}}};
    end else if (sx[VW-1] && !(&sx[VW-2:CW-1])) begin
      cx = {1'b1, {(CW-1){1'b0}}};
    end else begin
      cx = sx[CW-1:0];
    end
    if (!sy[VW-1] && (|sy[VW-2:CW-1])) begin
      cy = {1'b0, {(CW-1){1'b1}}};
    end else if (sy[VW-1] && !(&sy[VW-2:CW-1])) begin
      cy = {1'b1, {(CW-1){1'b0}}};
    end else begin
      cy = sy[CW-1:0];
    end
  end

  // Output register; degenerate anchors give a zero position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= res.vld;
      pos_x_r   <= res.inv ? '0 : cx;
      pos_y_r   <= res.inv ? '0 : cy;
      inv_r     <= res.inv;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.pos_x   = pos_x_r;
  assign out_ch.pos_y   = pos_y_r;
  assign out_ch.invalid = inv_r;
endmodule
